### hdl/vks_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the velocity key scanner.
// No dependencies; used by vks_key_step and velocity_key_scanner.
package vks_pkg;

  localparam int KEY_W   = 7;
  localparam int STAMP_W = 32;

  // Result kinds
  localparam logic [1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [1:0] EV_PEDAL    = 2'd2;

  // Per-key contact phase
  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_STARTED  = 2'd1,
    PH_ON       = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  // One input sample
  typedef struct packed {
    logic               action;
    logic [KEY_W-1:0]   key_index;
    logic               upper_contact;
    logic               lower_contact;
    logic [STAMP_W-1:0] now_us;
    logic               pedal_level;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [1:0]         event_kind;
    logic [KEY_W-1:0]   event_key;
    logic [STAMP_W-1:0] elapsed_us;
    logic               pedal_down;
  } out_item_t;

  // Decision of the per-key phase step
  typedef struct packed {
    logic               upd_phase;
    logic               upd_stamp;
    logic               emit;
    phase_t             new_phase;
    logic [1:0]         kind;
    logic [STAMP_W-1:0] elapsed;
  } key_step_t;

endpackage

### hdl/vks_key_step.sv
`timescale 1ns / 1ps
// Next-phase logic of one key: phase transitions, stamp capture, travel time.
// Depends on vks_pkg.
module vks_key_step (
  input  vks_pkg::phase_t             cur_phase,
  input  logic                        upper,
  input  logic                        lower,
  input  logic [vks_pkg::STAMP_W-1:0] now_us,
  input  logic [vks_pkg::STAMP_W-1:0] stamp,
  output vks_pkg::key_step_t          step
);
  import vks_pkg::*;

  logic [STAMP_W-1:0] travel;

  // Travel time wraps modulo 2^32
  assign travel = now_us - stamp;

  // One phase step per sample; upper contact checked first while started
  always_comb begin
    step           = '0;
    step.new_phase = cur_phase;
    step.elapsed   = travel;
    unique case (cur_phase)
      PH_OFF: begin
        if (upper) begin
          step.upd_phase = 1'b1;
          step.upd_stamp = 1'b1;
          step.new_phase = PH_STARTED;
        end
      end
      PH_STARTED: begin
        if (!upper) begin
          step.upd_phase = 1'b1;
          step.new_phase = PH_OFF;
        end else if (lower) begin
          step.upd_phase = 1'b1;
          step.new_phase = PH_ON;
          step.emit      = 1'b1;
          step.kind      = EV_NOTE_ON;
        end
      end
      PH_ON: begin
        if (!lower) begin
          step.upd_phase = 1'b1;
          step.upd_stamp = 1'b1;
          step.new_phase = PH_RELEASED;
        end
      end
      PH_RELEASED: begin
        if (!upper) begin
          step.upd_phase = 1'b1;
          step.new_phase = PH_OFF;
          step.emit      = 1'b1;
          step.kind      = EV_NOTE_OFF;
        end
      end
      default: begin
        step.new_phase = cur_phase;
      end
    endcase
  end

endmodule

### hdl/velocity_key_scanner.sv
`timescale 1ns / 1ps
// Two-contact velocity keyboard scanner, top level.
// Depends on vks_pkg and vks_key_step.
//
// Usage:
//   A sample transfers in at a clock edge with start high and busy low. A key
//   sample carries key index, both contact levels and a microsecond stamp; a
//   pedal sample carries the pedal line level.
//   Per-key phase and time stamp live in two single-port synchronous memories.
//   The accept edge launches the memory read; the next cycle (busy high)
//   decides the phase step, writes back and registers the result.
//   The result is registered into the output register at the end of the
//   execute cycle, so out_valid rises as busy falls, and the result transfers
//   while out_valid is high; it stands for exactly one cycle.
//   A new sample is not taken until the previous one has passed the memory
//   read and the write-back cycle. A new sample may be taken while the
//   previous result is on the output register.
//   Samples that change nothing give no result.
//   The receiver cannot stall; out_valid is a one-cycle strobe.
//   Reset (rst_n low, synchronous): all keys off through per-key valid bits,
//   pedal taken as released (high), no result pending. No clearing pass.
module velocity_key_scanner #(
  parameter int NUM_KEYS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  vks_pkg::in_item_t  in_item,
  output logic               out_valid,
  output vks_pkg::out_item_t out_item
);
  import vks_pkg::*;

  localparam int             KeyW   = $clog2(NUM_KEYS);
  localparam logic [KEY_W:0] KeyLim = (KEY_W + 1)'(NUM_KEYS);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic               last_pedal_r;

  phase_t             phase_mem [NUM_KEYS];
  logic [STAMP_W-1:0] stamp_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] phase_vld_r;

  phase_t             phase_rd_r;
  logic [STAMP_W-1:0] stamp_rd_r;
  logic               vld_rd_r;
  logic               in_range_r;
  in_item_t           item_r;

  logic               accept;
  logic               exec;
  logic [KeyW-1:0]    rd_idx;
  logic [KeyW-1:0]    wr_idx;
  phase_t             cur_phase;
  key_step_t          step;
  logic               key_live;
  logic               phase_we;
  logic               stamp_we;

  assign accept   = start && (state_r == S_IDLE);
  assign exec     = (state_r == S_EXEC);
  assign busy     = exec;
  assign rd_idx   = in_item.key_index[KeyW-1:0];
  assign wr_idx   = item_r.key_index[KeyW-1:0];

  // Memory read on transfer; sample held for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      phase_rd_r <= phase_mem[rd_idx];
      stamp_rd_r <= stamp_mem[rd_idx];
      vld_rd_r   <= phase_vld_r[rd_idx];
      in_range_r <= ({1'b0, in_item.key_index} < KeyLim);
      item_r     <= in_item;
    end
  end

  // Never-written keys read as off
  assign cur_phase = vld_rd_r ? phase_rd_r : PH_OFF;

  vks_key_step u_step (
    .cur_phase (cur_phase),
    .upper     (item_r.upper_contact),
    .lower     (item_r.lower_contact),
    .now_us    (item_r.now_us),
    .stamp     (stamp_rd_r),
    .step      (step)
  );

  assign key_live = exec && !item_r.action && in_range_r;
  assign phase_we = key_live && step.upd_phase;
  assign stamp_we = key_live && step.upd_stamp;

  // Write-back; the next read comes only after it, so no forwarding needed
  always_ff @(posedge clk) begin
    if (phase_we) begin
      phase_mem[wr_idx] <= step.new_phase;
    end
    if (stamp_we) begin
      stamp_mem[wr_idx] <= item_r.now_us;
    end
  end

  // Per-key valid bits stand in for the phase reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_vld_r <= '0;
    end else if (phase_we) begin
      phase_vld_r[wr_idx] <= 1'b1;
    end
  end

  // Sequencer, pedal state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_pedal_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          if (item_r.action) begin
            out_valid_r             <= (item_r.pedal_level != last_pedal_r);
            last_pedal_r            <= item_r.pedal_level;
            out_item_r.event_kind   <= EV_PEDAL;
            out_item_r.event_key    <= '0;
            out_item_r.elapsed_us   <= '0;
            out_item_r.pedal_down   <= !item_r.pedal_level;
          end else begin
            out_valid_r             <= in_range_r && step.emit;
            out_item_r.event_kind   <= step.kind;
            out_item_r.event_key    <= item_r.key_index;
            out_item_r.elapsed_us   <= step.elapsed;
            out_item_r.pedal_down   <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
